// File: sv/vvr_pkg.sv
// Shared types, constants and helpers of the velocity Verlet reflecting step.
package vvr_pkg;

  localparam int DIMENSIONS = 3;
  localparam int LATENCY    = 12;

  typedef enum logic [2:0] {
    REG_STEP_SIZE  = 3'd0,
    REG_HALF_STEP  = 3'd1,
    REG_REFLECT    = 3'd2,
    REG_BOUNDS_X   = 3'd3,
    REG_BOUNDS_Y   = 3'd4,
    REG_BOUNDS_Z   = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } clip_t;

  // Inputs of the wall stage: position and velocity after the step, walls of the axis.
  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] lo_wall;
    logic [31:0] hi_wall;
    logic        lo_en;
    logic        hi_en;
    logic        sat;
  } mirror_in_t;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] vel;
    logic [1:0]  refl;
    logic        sat;
  } mirror_out_t;

  // Clips a signed 52 bit value to the signed 32 bit range.
  function automatic clip_t sat32(input logic [51:0] x);
    clip_t c;
    if (!x[51] && (|x[50:31])) begin
      c.sat = 1'b1;
      c.val = 32'h7FFF_FFFF;
    end else if (x[51] && !(&x[50:31])) begin
      c.sat = 1'b1;
      c.val = 32'h8000_0000;
    end else begin
      c.sat = 1'b0;
      c.val = x[31:0];
    end
    return c;
  endfunction

endpackage

// File: sv/vvr_scale.sv
// Three stage unit: rounded (value * Q8.24 coefficient) >> 24, ties away from zero.
module vvr_scale
  import vvr_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [41:0] value,
  input  logic [31:0] coef,
  output logic [50:0] result
);

  logic        neg1, neg2;
  logic [40:0] mag1;
  logic [63:0] prod_lo;
  logic [40:0] prod_hi;
  logic [49:0] rmag;

  // The magnitude stays below 2^41, so the top bit of the negation is dropped.
  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= value[41];
      mag1 <= value[41] ? 41'(-value) : value[40:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2    <= neg1;
      prod_lo <= 64'(mag1[31:0]) * 64'(coef);
      prod_hi <= 41'(mag1[40:32]) * 41'(coef);
    end
  end

  assign rmag = {1'b0, prod_hi, 8'b0} + 50'(prod_lo[63:24]) + 50'(prod_lo[23]);

  always_ff @(posedge clk) begin
    if (en) begin
      result <= neg2 ? -{1'b0, rmag} : {1'b0, rmag};
    end
  end

endmodule

// File: sv/vvr_mirror.sv
// Two stage wall reflection: lower wall first, then upper wall and the final clip.
module vvr_mirror
  import vvr_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  mirror_in_t  mi,
  output mirror_out_t mo
);

  logic [34:0] pos1;
  logic [32:0] vel1;
  logic [31:0] hi1;
  logic        hi_en1, sat1, lo_hit1;

  logic        lo_hit, hi_hit;
  logic [34:0] lo_twice, pos_ext;
  logic [36:0] pos2;
  logic [33:0] vel2;
  clip_t       pc, vc;

  always_comb begin
    lo_hit   = mi.lo_en && ($signed(mi.pos) < $signed(mi.lo_wall));
    lo_twice = {{2{mi.lo_wall[31]}}, mi.lo_wall, 1'b0};
    pos_ext  = {{3{mi.pos[31]}}, mi.pos};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_hit1 <= lo_hit;
      pos1    <= lo_hit ? lo_twice - pos_ext : pos_ext;
      vel1    <= lo_hit ? -{mi.vel[31], mi.vel} : {mi.vel[31], mi.vel};
      hi1     <= mi.hi_wall;
      hi_en1  <= mi.hi_en;
      sat1    <= mi.sat;
    end
  end

  always_comb begin
    hi_hit = hi_en1 && ($signed(pos1) > $signed({{3{hi1[31]}}, hi1}));
    pos2   = hi_hit ? {{4{hi1[31]}}, hi1, 1'b0} - {{2{pos1[34]}}, pos1}
                    : {{2{pos1[34]}}, pos1};
    vel2   = hi_hit ? -{vel1[32], vel1} : {vel1[32], vel1};
    pc     = sat32({{15{pos2[36]}}, pos2});
    vc     = sat32({{18{vel2[33]}}, vel2});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mo.pos  <= pc.val;
      mo.vel  <= vc.val;
      mo.refl <= {hi_hit, lo_hit1};
      mo.sat  <= sat1 | pc.sat | vc.sat;
    end
  end

endmodule

// File: sv/velocity_verlet_reflect_step.sv
// Top level of the velocity Verlet step with reflecting walls, one particle axis per item.
//
// Usage: an item on the slave stream carries one axis of one particle; the master
// stream returns one result item for it, in order.
// s_tdata: position_in, velocity_in, force_now, force_before (32 bits each, Q16.16).
// s_tuser: axis (2 bits), is_fixed (1 bit).
// m_tdata: position_out, velocity_out, kept_old_force; m_tuser: clear_force,
// reflected (2 bits), saturated.
// Registers are written through cfg_wr_en, cfg_index and cfg_data; the user must write
// them only while the block is idle (unenforced); indexes beyond the list are ignored.
// There are 12 register stages: the input register, three stages of scaling by
// dt/(2m), the velocity add, the inner sum, three stages of scaling by dt, the
// position add and two wall stages. m_tvalid rises when the accepted item reaches the
// last stage. One item is accepted in every cycle in which the pipeline does not hold.
// The whole pipeline advances together; when m_tvalid is high and m_tready is low
// it holds, and s_tready falls, so nothing is lost or repeated.
// Reset (synchronous rst) empties the pipeline and clears all config registers to zero.
module velocity_verlet_reflect_step
  import vvr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // position_in, velocity_in, force_now, force_before
  input  logic [2:0]   s_tuser,   // axis, is_fixed
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // position_out, velocity_out, kept_old_force
  output logic [3:0]   m_tuser,   // clear_force, reflected[1:0], saturated
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  typedef struct packed {
    logic        is_fixed;
    logic [31:0] pos_in;
    logic [31:0] vel_in;
    logic [31:0] f_now;
    logic [31:0] kept;
    logic        lo_en;
    logic        hi_en;
    logic [31:0] lo_wall;
    logic [31:0] hi_wall;
    logic [41:0] fsum;
    logic [31:0] vel_new;
    logic        sat;
    logic [50:0] s2;
    logic [41:0] inner;
    logic [31:0] pos_new;
  } payload_t;

  logic [31:0] step_size, half_step;
  logic [5:0]  reflect_mask;
  logic [63:0] bounds_x, bounds_y, bounds_z;

  payload_t    d   [1:LATENCY];
  payload_t    nxt [1:LATENCY];
  logic        vld [1:LATENCY];
  logic        en;

  logic [50:0] s_a, s_b, s_c;
  logic [1:0]  axis;
  logic [31:0] f_now_in, f_old_in;
  logic [63:0] bsel;
  logic        lo_bit, hi_bit, axis_ok;
  clip_t       vclip, pclip;
  mirror_in_t  mi;
  mirror_out_t mo;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size    <= '0;
      half_step    <= '0;
      reflect_mask <= '0;
      bounds_x     <= '0;
      bounds_y     <= '0;
      bounds_z     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STEP_SIZE: step_size    <= cfg_data[31:0];
        REG_HALF_STEP: half_step    <= cfg_data[31:0];
        REG_REFLECT:   reflect_mask <= cfg_data[5:0];
        REG_BOUNDS_X:  bounds_x     <= cfg_data;
        REG_BOUNDS_Y:  bounds_y     <= cfg_data;
        REG_BOUNDS_Z:  bounds_z     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !vld[LATENCY] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LATENCY];

  assign axis     = s_tuser[1:0];
  assign f_now_in = s_tdata[95:64];
  assign f_old_in = s_tdata[127:96];
  assign axis_ok  = (32'(axis) < DIMENSIONS);

  always_comb begin
    unique case (axis)
      AXIS_X:  begin bsel = bounds_x; lo_bit = reflect_mask[0]; hi_bit = reflect_mask[1]; end
      AXIS_Y:  begin bsel = bounds_y; lo_bit = reflect_mask[2]; hi_bit = reflect_mask[3]; end
      AXIS_Z:  begin bsel = bounds_z; lo_bit = reflect_mask[4]; hi_bit = reflect_mask[5]; end
      default: begin bsel = '0;       lo_bit = 1'b0;            hi_bit = 1'b0;            end
    endcase
  end

  always_comb begin
    nxt[1]          = d[1];
    nxt[1].is_fixed = s_tuser[2];
    nxt[1].pos_in   = s_tdata[31:0];
    nxt[1].vel_in   = s_tdata[63:32];
    nxt[1].f_now    = f_now_in;
    nxt[1].kept     = s_tuser[2] ? f_old_in : f_now_in;
    nxt[1].lo_en    = axis_ok && lo_bit;
    nxt[1].hi_en    = axis_ok && hi_bit;
    nxt[1].lo_wall  = bsel[31:0];
    nxt[1].hi_wall  = bsel[63:32];
    nxt[1].fsum     = {{10{f_now_in[31]}}, f_now_in} + {{10{f_old_in[31]}}, f_old_in};
    for (int k = 2; k <= LATENCY; k++) begin
      nxt[k] = d[k-1];
    end
    // Velocity update, clipped to 32 bits.
    vclip          = sat32({{20{d[4].vel_in[31]}}, d[4].vel_in} + {s_a[50], s_a});
    nxt[5].vel_new = vclip.val;
    nxt[5].sat     = vclip.sat;
    nxt[5].s2      = s_b;
    // The sum stays below 2^41 in magnitude.
    nxt[6].inner   = {{10{d[5].vel_new[31]}}, d[5].vel_new} + d[5].s2[41:0];
    // Position update, clipped to 32 bits.
    pclip          = sat32({{20{d[9].pos_in[31]}}, d[9].pos_in} + {s_c[50], s_c});
    nxt[10].pos_new = pclip.val;
    nxt[10].sat     = d[9].sat | pclip.sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= LATENCY; k++) begin
        d[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LATENCY; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= s_tvalid;
      for (int k = 2; k <= LATENCY; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  vvr_scale u_scale_sum (
    .clk    (clk),
    .en     (en),
    .value  (d[1].fsum),
    .coef   (half_step),
    .result (s_a)
  );

  vvr_scale u_scale_force (
    .clk    (clk),
    .en     (en),
    .value  ({{10{d[1].f_now[31]}}, d[1].f_now}),
    .coef   (half_step),
    .result (s_b)
  );

  vvr_scale u_scale_step (
    .clk    (clk),
    .en     (en),
    .value  (d[6].inner),
    .coef   (step_size),
    .result (s_c)
  );

  always_comb begin
    mi.pos     = d[10].pos_new;
    mi.vel     = d[10].vel_new;
    mi.lo_wall = d[10].lo_wall;
    mi.hi_wall = d[10].hi_wall;
    mi.lo_en   = d[10].lo_en;
    mi.hi_en   = d[10].hi_en;
    mi.sat     = d[10].sat;
  end

  vvr_mirror u_mirror (
    .clk (clk),
    .en  (en),
    .mi  (mi),
    .mo  (mo)
  );

  // A pinned particle passes through untouched.
  always_comb begin
    if (d[LATENCY].is_fixed) begin
      m_tdata = {d[LATENCY].kept, d[LATENCY].vel_in, d[LATENCY].pos_in};
      m_tuser = 4'b0000;
    end else begin
      m_tdata = {d[LATENCY].kept, mo.vel, mo.pos};
      m_tuser = {mo.sat, mo.refl, 1'b1};
    end
  end

endmodule
